// File: rtl/core/decimal_with_thousands_commas_macros.svh
// Assertion macros for the decimal formatter.
`ifndef DECIMAL_WITH_THOUSANDS_COMMAS_MACROS_SVH
`define DECIMAL_WITH_THOUSANDS_COMMAS_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define DWTC_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DWTC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define DWTC_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define DWTC_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// File: rtl/core/dwtc_pkg.sv
// Shared types and character constants for the decimal formatter.
`timescale 1ns / 1ps

package dwtc_pkg;

    localparam int VALUE_W      = 31;
    localparam int VALUE_DIGITS = 10;
    localparam int BCD_W        = 4;
    localparam int CHAR_W       = 6;

    typedef logic [BCD_W-1:0]  t_bcd;
    typedef logic [CHAR_W-1:0] t_char;

    localparam t_char CHAR_ZERO  = 6'd48;
    localparam t_char CHAR_NINE  = 6'd57;
    localparam t_char CHAR_COMMA = 6'd44;
    localparam t_char CHAR_MINUS = 6'd45;

    typedef struct packed {
        logic clear;
        logic conv;
        logic move;
    } t_cell_ctrl;

endpackage

// File: rtl/core/dwtc_cell.sv
// One decimal digit cell: clear on load, shift-and-add-3 during conversion, digit shift during output.
`timescale 1ns / 1ps

module dwtc_cell (
    input  logic                   i_clk,
    input  dwtc_pkg::t_cell_ctrl   i_ctrl,
    input  logic                   i_bit,
    input  dwtc_pkg::t_bcd         i_digit,
    output logic                   o_bit,
    output dwtc_pkg::t_bcd         o_digit
);
    import dwtc_pkg::*;

    t_bcd r_digit;
    t_bcd n_digit;
    t_bcd w_adj;

    // correct before the shift so the digit stays decimal
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit   = w_adj[BCD_W-1];
    assign o_digit = r_digit;

    always_comb begin
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.conv) begin
            n_digit = {w_adj[BCD_W-2:0], i_bit};
        end else if (i_ctrl.move) begin
            n_digit = i_digit;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// File: rtl/core/decimal_with_thousands_commas.sv
// One number passes a load step, one conversion shift per binary bit through the
// digit-cell chain, a step per skipped leading zero, then one character per cycle.
// busy stays high until the word carrying o_last is on the ports.
// Results cannot be stalled.
// Reset (i_rst_n low, synchronous) returns to idle and drops o_valid.
`timescale 1ns / 1ps

module decimal_with_thousands_commas #(
    parameter int MAX_DIGITS = 9,
    parameter int GROUP_SIZE = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [dwtc_pkg::VALUE_W-1:0] i_value,
    output logic                         busy,
    output logic                         o_valid,
    output dwtc_pkg::t_char              o_char_code,
    output logic                         o_last
);
    import dwtc_pkg::*;

`include "decimal_with_thousands_commas_macros.svh"

    function automatic logic [63:0] f_limit(input int n);
        logic [63:0] lim;
        lim = 64'd1;
        for (int i = 0; i < n; i++) begin
            lim = lim * 64'd10;
        end
        return lim - 64'd1;
    endfunction

    localparam int          NCELL    = (MAX_DIGITS < VALUE_DIGITS) ? MAX_DIGITS : VALUE_DIGITS;
    localparam int          REM_W    = $clog2(NCELL + 1);
    localparam int          GRP_W    = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam int          GRP_INIT = NCELL % GROUP_SIZE;
    localparam int          CNT_W    = $clog2(VALUE_W);
    localparam logic [63:0] LIMIT    = f_limit(MAX_DIGITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_CONV  = 3'd2;
    localparam logic [2:0] S_SKIP  = 3'd3;
    localparam logic [2:0] S_SIGN  = 3'd4;
    localparam logic [2:0] S_DIGIT = 3'd5;
    localparam logic [2:0] S_COMMA = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [VALUE_W-1:0] r_bin, n_bin;
    logic               r_neg, n_neg;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [GRP_W-1:0]   r_grp, n_grp;
    t_char              r_char, n_char;
    logic               r_last, n_last;
    logic               r_valid, n_valid;

    t_cell_ctrl         w_ctrl;
    logic [VALUE_W-1:0] w_abs;
    logic [VALUE_W-1:0] w_sat;
    logic [REM_W-1:0]   w_rem_dec;
    logic [GRP_W-1:0]   w_grp_dec;
    t_bcd               w_top;
    logic [NCELL:0]     w_carry;
    t_bcd               w_digit [NCELL];
    logic               w_out_comma;
    logic               w_out_digit;

    // digit chain: cell 0 is the units end, the top cell is the most significant
    assign w_carry[0] = r_bin[VALUE_W-1];

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        if (k == 0) begin : g_first
            dwtc_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_bit   (w_carry[k]),
                .i_digit ('0),
                .o_bit   (w_carry[k+1]),
                .o_digit (w_digit[k])
            );
        end else begin : g_rest
            dwtc_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_bit   (w_carry[k]),
                .i_digit (w_digit[k-1]),
                .o_bit   (w_carry[k+1]),
                .o_digit (w_digit[k])
            );
        end
    end

    assign w_top     = w_digit[NCELL-1];
    assign w_abs     = r_neg ? (~r_bin + VALUE_W'(1)) : r_bin;
    assign w_sat     = (64'(w_abs) > LIMIT) ? LIMIT[VALUE_W-1:0] : w_abs;
    assign w_rem_dec = r_rem - REM_W'(1);
    assign w_grp_dec = (r_grp == '0) ? GRP_W'(GROUP_SIZE - 1) : (r_grp - GRP_W'(1));

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_grp   = r_grp;
        n_char  = r_char;
        n_last  = 1'b0;
        n_valid = 1'b0;
        w_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_bin   = i_value;
                    n_neg   = i_value[VALUE_W-1];
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                w_ctrl.clear = 1'b1;
                n_bin   = w_sat;
                n_cnt   = CNT_W'(VALUE_W - 1);
                n_rem   = REM_W'(NCELL);
                n_grp   = GRP_W'(GRP_INIT);
                n_state = S_CONV;
            end
            S_CONV: begin
                w_ctrl.conv = 1'b1;
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = S_SKIP;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if ((w_top == '0) && (r_rem > REM_W'(1))) begin
                    w_ctrl.move = 1'b1;
                    n_rem = w_rem_dec;
                    n_grp = w_grp_dec;
                end else begin
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                n_valid = 1'b1;
                n_char  = CHAR_MINUS;
                n_state = S_DIGIT;
            end
            S_DIGIT: begin
                w_ctrl.move = 1'b1;
                n_valid = 1'b1;
                n_char  = CHAR_ZERO + {2'b00, w_top};
                n_rem   = w_rem_dec;
                n_grp   = w_grp_dec;
                if (w_rem_dec == '0) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else if (w_grp_dec == '0) begin
                    n_state = S_COMMA;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_COMMA: begin
                n_valid = 1'b1;
                n_char  = CHAR_COMMA;
                n_state = S_DIGIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_grp  <= n_grp;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    assign w_out_comma = o_valid && (o_char_code == CHAR_COMMA);
    assign w_out_digit = o_valid && (o_char_code >= CHAR_ZERO) && (o_char_code <= CHAR_NINE);

    `DWTC_ASSERT_NOW(a_last_frees, i_clk, i_rst_n, o_valid && o_last, !busy)
    `DWTC_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, o_valid && !o_last, busy)
    `DWTC_ASSERT_NEXT(a_start_quiet, i_clk, i_rst_n, start && !busy, !o_valid)
    `DWTC_ASSERT_NEXT(a_comma_digit, i_clk, i_rst_n, w_out_comma, w_out_digit)
    `DWTC_ASSERT_NOW(a_minus_first, i_clk, i_rst_n, o_valid && (o_char_code == CHAR_MINUS), !o_last)
    `DWTC_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, r_state == S_CONV, !w_carry[NCELL])

endmodule
